[design/gossip_weighted_average_node_macros.svh]
// Assertion helpers for the gossip average node.
`ifndef GOSSIP_WEIGHTED_AVERAGE_NODE_MACROS_SVH
`define GOSSIP_WEIGHTED_AVERAGE_NODE_MACROS_SVH
`ifndef SYNTHESIS
`define GWAN_ASSERT_HOLD(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gossip node assertion failed");
`define GWAN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gossip node assertion failed");
`else
`define GWAN_ASSERT_HOLD(label, ante, cons)
`define GWAN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/gwan_pkg.sv]
package gwan_pkg;

  localparam int V_W   = 48;
  localparam int OP_W  = 49;
  localparam int DEN_W = 50;
  localparam int ACC_W = 98;
  localparam int CNT_W = $clog2(ACC_W);

  localparam logic [2:0] OP_RECV = 3'd0;
  localparam logic [2:0] OP_SEND = 3'd1;
  localparam logic [2:0] OP_UP   = 3'd2;
  localparam logic [2:0] OP_DOWN = 3'd3;
  localparam logic [2:0] OP_VC   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic [16:0] QUANTUM_RST = 17'd2731;

  localparam logic signed [V_W-1:0] S48MAX = {1'b0, {(V_W-1){1'b1}}};
  localparam logic signed [V_W-1:0] S48MIN = {1'b1, {(V_W-1){1'b0}}};

  typedef struct packed {
    logic [63:0]              key;
    logic [47:0]              addr;
    logic signed [V_W-1:0]    sent_v;
    logic signed [V_W-1:0]    sent_w;
    logic signed [V_W-1:0]    recv_v;
    logic signed [V_W-1:0]    recv_w;
  } entry_t;

  typedef struct packed {
    logic signed [OP_W-1:0]  v1;
    logic signed [OP_W-1:0]  w1;
    logic signed [OP_W-1:0]  v2;
    logic signed [OP_W-1:0]  w2;
    logic signed [DEN_W-1:0] den;
  } arith_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic signed [V_W-1:0] quo;
    logic [V_W-1:0]        rem;
  } arith_rsp_t;

  function automatic logic signed [V_W-1:0] clamp48(input logic signed [DEN_W-1:0] x);
    logic signed [DEN_W-1:0] hi;
    logic signed [DEN_W-1:0] lo;
    hi = DEN_W'(S48MAX);
    lo = DEN_W'(S48MIN);
    if (x > hi) return S48MAX;
    else if (x < lo) return S48MIN;
    else return x[V_W-1:0];
  endfunction

  function automatic logic [OP_W-1:0] mag_op(input logic signed [OP_W-1:0] x);
    return x[OP_W-1] ? OP_W'(-x) : OP_W'(x);
  endfunction

endpackage

[design/gossip_weighted_average_node.sv]
// A weighted merge runs in the shared multiply/divide unit (two 49-step shift-add
// products, a sign fix-up step and a 98-step restoring division). Receive: a table
// scan of up to MAX_NEIGHBORS entries plus up to two merges; send: one modulo pass,
// a pick walk over up to MAX_NEIGHBORS entries and up to two merges. Words are taken
// one at a time, the next accepted the cycle after its result enters the output register.
// Reset (synchronous, rst_n low) empties the table, sets estimate weight to one, quantum 2731.
`include "gossip_weighted_average_node_macros.svh"
module gossip_weighted_average_node #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key, neighbor_addr, msg_value, msg_weight, local_sample, random_word
  input  logic [271:0] in_tdata,
  // operation
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // send_addr, send_value, send_weight, estimate_value, estimate_weight,
  // current_local, neighbor_count
  output logic [295:0] out_tdata,
  // send_valid, status
  output logic [2:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import gwan_pkg::*;

  localparam int CW    = $clog2(MAX_NEIGHBORS + 1);
  localparam int IW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int QSH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int QSH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SCAN_RD  = 5'd1;
  localparam logic [4:0] S_SCAN_CMP = 5'd2;
  localparam logic [4:0] S_NEW      = 5'd3;
  localparam logic [4:0] S_FOUND    = 5'd4;
  localparam logic [4:0] S_RECV1    = 5'd5;
  localparam logic [4:0] S_RECV1_W  = 5'd6;
  localparam logic [4:0] S_RECV2    = 5'd7;
  localparam logic [4:0] S_RECV2_W  = 5'd8;
  localparam logic [4:0] S_RECV_WB  = 5'd9;
  localparam logic [4:0] S_DOWN1    = 5'd10;
  localparam logic [4:0] S_DOWN1_W  = 5'd11;
  localparam logic [4:0] S_DOWN2    = 5'd12;
  localparam logic [4:0] S_DOWN2_W  = 5'd13;
  localparam logic [4:0] S_DOWN_END = 5'd14;
  localparam logic [4:0] S_MOD      = 5'd15;
  localparam logic [4:0] S_MOD_W    = 5'd16;
  localparam logic [4:0] S_PICK     = 5'd17;
  localparam logic [4:0] S_PICK_RD  = 5'd18;
  localparam logic [4:0] S_PICK_LD  = 5'd19;
  localparam logic [4:0] S_SENDA    = 5'd20;
  localparam logic [4:0] S_SENDA_W  = 5'd21;
  localparam logic [4:0] S_SENDB    = 5'd22;
  localparam logic [4:0] S_SENDB_W  = 5'd23;
  localparam logic [4:0] S_SEND_WB  = 5'd24;
  localparam logic [4:0] S_VC       = 5'd25;
  localparam logic [4:0] S_VC_W     = 5'd26;
  localparam logic [4:0] S_DONE     = 5'd27;

  logic [4:0]             state_r;
  logic [16:0]            quantum_r;
  logic [MAX_NEIGHBORS-1:0] valid_r;
  logic [CW-1:0]          count_r;
  logic signed [V_W-1:0]  est_v_r, est_w_r, unr_v_r, unr_w_r, local_r;

  logic [2:0]             op_r;
  logic [63:0]            key_r;
  logic [47:0]            addr_r;
  logic signed [V_W-1:0]  mv_r, mw_r, ls_r;
  logic [15:0]            rnd_r;

  logic [IW-1:0]          idx_r, slot_r, free_r;
  logic                   free_found_r;
  logic [CW-1:0]          k_r;
  entry_t                 entry_r;
  logic signed [V_W-1:0]  dv_r, dw_r;
  logic signed [DEN_W-1:0] den_r;
  logic [1:0]             status_r;
  logic                   snd_r;

  logic                   out_valid_r;
  logic [295:0]           out_data_r;
  logic [2:0]             out_user_r;

  arith_req_t             req;
  arith_rsp_t             arith_rsp;
  logic                   arith_start;
  logic                   issue;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  entry_t                 mem_wdata;
  entry_t                 mem_rdata;
  entry_t                 new_entry;

  logic signed [DEN_W-1:0] qf;
  logic                    ge2q;
  logic signed [V_W-1:0]   lim;
  logic signed [V_W-1:0]   t;
  logic signed [V_W-1:0]   half;
  logic                    hit;
  logic                    in_acc;
  logic                    cfg_wr;

  assign in_tready  = state_r == S_IDLE;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {15'd0, quantum_r};

  always_comb begin
    qf   = $signed((DEN_W'(quantum_r) << QSH_L) >> QSH_R);
    ge2q = DEN_W'(est_w_r) >= (qf <<< 1);
    lim  = clamp48(DEN_W'(est_w_r) - qf);
    t    = (unr_w_r < lim) ? unr_w_r : lim;
    half = est_w_r >>> 1;
    hit  = valid_r[idx_r] && (mem_rdata.key == key_r);
  end

  always_comb begin
    req   = '0;
    issue = 1'b0;
    unique case (state_r)
      S_RECV1: begin
        issue  = 1'b1;
        req.v1 = OP_W'(mv_r);
        req.w1 = OP_W'(mw_r);
        req.v2 = OP_W'(entry_r.recv_v);
        req.w2 = -OP_W'(entry_r.recv_w);
        req.den = DEN_W'(mw_r) - DEN_W'(entry_r.recv_w);
      end
      S_RECV2: begin
        issue  = 1'b1;
        req.v1 = OP_W'(est_v_r);
        req.w1 = OP_W'(est_w_r);
        req.v2 = OP_W'(dv_r);
        req.w2 = OP_W'(dw_r);
        req.den = DEN_W'(est_w_r) + DEN_W'(dw_r);
      end
      S_DOWN1: begin
        issue  = 1'b1;
        req.v1 = OP_W'(est_v_r);
        req.w1 = OP_W'(est_w_r);
        req.v2 = OP_W'(entry_r.sent_v);
        req.w2 = OP_W'(entry_r.sent_w);
        req.den = DEN_W'(est_w_r) + DEN_W'(entry_r.sent_w);
      end
      S_DOWN2: begin
        issue  = 1'b1;
        req.v1 = OP_W'(unr_v_r);
        req.w1 = OP_W'(unr_w_r);
        req.v2 = OP_W'(entry_r.recv_v);
        req.w2 = OP_W'(entry_r.recv_w);
        req.den = DEN_W'(unr_w_r) + DEN_W'(entry_r.recv_w);
      end
      S_MOD: begin
        issue  = 1'b1;
        req.v1 = OP_W'(rnd_r);
        req.w1 = OP_W'(1);
        req.den = DEN_W'(count_r);
      end
      S_SENDA: begin
        issue  = ge2q;
        req.v1 = OP_W'(est_v_r);
        req.w1 = OP_W'(est_w_r);
        req.v2 = OP_W'(unr_v_r);
        req.w2 = -OP_W'(t);
        req.den = DEN_W'(est_w_r) - DEN_W'(t);
      end
      S_SENDB: begin
        issue  = ge2q;
        req.v1 = OP_W'(entry_r.sent_v);
        req.w1 = OP_W'(entry_r.sent_w);
        req.v2 = OP_W'(est_v_r);
        req.w2 = OP_W'(half);
        req.den = DEN_W'(entry_r.sent_w) + DEN_W'(half);
      end
      S_VC: begin
        issue  = est_w_r != '0;
        req.v1 = OP_W'(ls_r) - OP_W'(local_r);
        req.w1 = OP_W'(1) <<< FRAC_BITS;
        req.den = DEN_W'(est_w_r);
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    arith_start = issue && (req.den != '0);
  end

  always_comb begin
    new_entry        = '0;
    new_entry.key    = key_r;
    new_entry.addr   = addr_r;
    mem_we           = 1'b0;
    mem_waddr        = slot_r;
    mem_wdata        = entry_r;
    unique case (state_r)
      S_NEW: begin
        mem_we    = (op_r != OP_DOWN) && (count_r < CW'(MAX_NEIGHBORS));
        mem_waddr = free_r;
        mem_wdata = new_entry;
      end
      S_RECV_WB: begin
        mem_we           = 1'b1;
        mem_wdata.recv_v = mv_r;
        mem_wdata.recv_w = mw_r;
      end
      S_SEND_WB: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  gwan_table #(
    .DEPTH (MAX_NEIGHBORS),
    .IW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  gwan_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (arith_start),
    .req   (req),
    .rsp   (arith_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      quantum_r   <= QUANTUM_RST;
      valid_r     <= '0;
      count_r     <= '0;
      est_v_r     <= '0;
      est_w_r     <= V_W'(1) <<< FRAC_BITS;
      unr_v_r     <= '0;
      unr_w_r     <= '0;
      local_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && !cfg_paddr[2]) begin
        quantum_r <= cfg_pwdata[16:0];
      end
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r         <= in_tuser;
            key_r        <= in_tdata[63:0];
            addr_r       <= in_tdata[111:64];
            mv_r         <= in_tdata[159:112];
            mw_r         <= in_tdata[207:160];
            ls_r         <= in_tdata[255:208];
            rnd_r        <= in_tdata[271:256];
            status_r     <= ((in_tuser == OP_SEND) && (count_r == '0)) ? ST_NONE : ST_OK;
            snd_r        <= 1'b0;
            idx_r        <= '0;
            free_found_r <= 1'b0;
            unique case (in_tuser)
              OP_RECV, OP_UP, OP_DOWN: state_r <= S_SCAN_RD;
              OP_SEND: begin
                if (count_r == '0) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_MOD;
                end
              end
              OP_VC:   state_r <= S_VC;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (hit) begin
            entry_r <= mem_rdata;
            slot_r  <= idx_r;
            state_r <= S_FOUND;
          end else begin
            if (!valid_r[idx_r] && !free_found_r) begin
              free_r       <= idx_r;
              free_found_r <= 1'b1;
            end
            if (idx_r == IW'(MAX_NEIGHBORS - 1)) begin
              state_r <= S_NEW;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_FOUND: begin
          unique case (op_r)
            OP_RECV: state_r <= S_RECV1;
            OP_DOWN: state_r <= S_DOWN1;
            default: state_r <= S_DONE;
          endcase
        end
        S_NEW: begin
          if (op_r == OP_DOWN) begin
            status_r <= ST_NONE;
            state_r  <= S_DONE;
          end else if (count_r >= CW'(MAX_NEIGHBORS)) begin
            status_r <= ST_FULL;
            state_r  <= S_DONE;
          end else begin
            valid_r[free_r] <= 1'b1;
            count_r         <= count_r + 1'b1;
            entry_r         <= new_entry;
            slot_r          <= free_r;
            state_r         <= (op_r == OP_RECV) ? S_RECV1 : S_DONE;
          end
        end
        S_RECV1: begin
          den_r <= req.den;
          if (arith_start) begin
            state_r <= S_RECV1_W;
          end else begin
            status_r <= ST_ZERO;
            state_r  <= S_RECV_WB;
          end
        end
        S_RECV1_W: begin
          if (arith_rsp.done) begin
            dv_r    <= arith_rsp.quo;
            dw_r    <= clamp48(den_r);
            state_r <= S_RECV2;
          end
        end
        S_RECV2: begin
          den_r <= req.den;
          if (arith_start) begin
            state_r <= S_RECV2_W;
          end else begin
            status_r <= ST_ZERO;
            state_r  <= S_RECV_WB;
          end
        end
        S_RECV2_W: begin
          if (arith_rsp.done) begin
            est_v_r <= arith_rsp.quo;
            est_w_r <= clamp48(den_r);
            state_r <= S_RECV_WB;
          end
        end
        S_RECV_WB: state_r <= S_DONE;
        S_DOWN1: begin
          den_r <= req.den;
          if (arith_start) begin
            state_r <= S_DOWN1_W;
          end else begin
            status_r <= ST_ZERO;
            state_r  <= S_DOWN2;
          end
        end
        S_DOWN1_W: begin
          if (arith_rsp.done) begin
            est_v_r <= arith_rsp.quo;
            est_w_r <= clamp48(den_r);
            state_r <= S_DOWN2;
          end
        end
        S_DOWN2: begin
          den_r <= req.den;
          if (arith_start) begin
            state_r <= S_DOWN2_W;
          end else begin
            status_r <= ST_ZERO;
            state_r  <= S_DOWN_END;
          end
        end
        S_DOWN2_W: begin
          if (arith_rsp.done) begin
            unr_v_r <= arith_rsp.quo;
            unr_w_r <= clamp48(den_r);
            state_r <= S_DOWN_END;
          end
        end
        S_DOWN_END: begin
          valid_r[slot_r] <= 1'b0;
          count_r         <= count_r - 1'b1;
          state_r         <= S_DONE;
        end
        S_MOD: state_r <= S_MOD_W;
        S_MOD_W: begin
          if (arith_rsp.done) begin
            k_r     <= arith_rsp.rem[CW-1:0];
            idx_r   <= '0;
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (valid_r[idx_r] && k_r == '0) begin
            slot_r  <= idx_r;
            state_r <= S_PICK_RD;
          end else begin
            if (valid_r[idx_r]) begin
              k_r <= k_r - 1'b1;
            end
            if (idx_r == IW'(MAX_NEIGHBORS - 1)) begin
              idx_r   <= '0;
              slot_r  <= '0;
              state_r <= S_PICK_RD;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_PICK_RD: state_r <= S_PICK_LD;
        S_PICK_LD: begin
          entry_r <= mem_rdata;
          state_r <= S_SENDA;
        end
        S_SENDA: begin
          den_r <= req.den;
          if (ge2q) begin
            unr_w_r <= clamp48(DEN_W'(unr_w_r) - DEN_W'(t));
            if (arith_start) begin
              state_r <= S_SENDA_W;
            end else begin
              status_r <= ST_ZERO;
              state_r  <= S_SENDB;
            end
          end else begin
            state_r <= S_SENDB;
          end
        end
        S_SENDA_W: begin
          if (arith_rsp.done) begin
            est_v_r <= arith_rsp.quo;
            est_w_r <= clamp48(den_r);
            state_r <= S_SENDB;
          end
        end
        S_SENDB: begin
          den_r <= req.den;
          if (ge2q) begin
            est_w_r <= half;
            if (arith_start) begin
              state_r <= S_SENDB_W;
            end else begin
              status_r <= ST_ZERO;
              state_r  <= S_SEND_WB;
            end
          end else begin
            state_r <= S_SEND_WB;
          end
        end
        S_SENDB_W: begin
          if (arith_rsp.done) begin
            entry_r.sent_v <= arith_rsp.quo;
            entry_r.sent_w <= clamp48(den_r);
            state_r        <= S_SEND_WB;
          end
        end
        S_SEND_WB: begin
          snd_r   <= 1'b1;
          state_r <= S_DONE;
        end
        S_VC: begin
          local_r <= ls_r;
          if (arith_start) begin
            state_r <= S_VC_W;
          end else begin
            status_r <= ST_ZERO;
            state_r  <= S_DONE;
          end
        end
        S_VC_W: begin
          if (arith_rsp.done) begin
            est_v_r <= clamp48(DEN_W'(est_v_r) + DEN_W'(arith_rsp.quo));
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= {status_r, snd_r};
            out_data_r  <= {3'd0, 5'(count_r), local_r, est_w_r, est_v_r,
                            snd_r ? entry_r.sent_w : '0,
                            snd_r ? entry_r.sent_v : '0,
                            snd_r ? entry_r.addr : 48'd0};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GWAN_ASSERT_HOLD(a_count_matches, 1'b1, count_r == CW'($countones(valid_r)))
  `GWAN_ASSERT_HOLD(a_start_when_free, arith_start, !arith_rsp.busy)
  `GWAN_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE)
  `GWAN_ASSERT_HOLD(a_send_has_target, out_tvalid && out_tuser[0], out_tuser[2:1] != ST_NONE)

endmodule

[design/gwan_table.sv]
module gwan_table #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  gwan_pkg::entry_t wdata,
  input  logic [IW-1:0]    raddr,
  output gwan_pkg::entry_t rdata
);
  import gwan_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/gwan_arith.sv]
module gwan_arith (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  gwan_pkg::arith_req_t req,
  output gwan_pkg::arith_rsp_t rsp
);
  import gwan_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_PREP = 2'd2;
  localparam logic [1:0] A_DIV  = 2'd3;

  logic [1:0]              st_r;
  logic                    phase_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ACC_W-1:0]        a_r;
  logic [OP_W-1:0]         b_r;
  logic                    neg_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [OP_W-1:0]  v2_r;
  logic signed [OP_W-1:0]  w2_r;
  logic [DEN_W-1:0]        dmag_r;
  logic                    dneg_r;
  logic [ACC_W-1:0]        num_r;
  logic [DEN_W-1:0]        rem_r;
  logic [ACC_W-1:0]        quo_r;
  logic                    qneg_r;
  logic                    done_r;

  logic signed [ACC_W-1:0] acc_add;
  logic [DEN_W-1:0]        rem_sh;
  logic                    ge;
  logic                    big;

  always_comb begin
    if (b_r[0]) begin
      acc_add = neg_r ? acc_r - $signed(a_r) : acc_r + $signed(a_r);
    end else begin
      acc_add = acc_r;
    end
    rem_sh = {rem_r[DEN_W-2:0], num_r[ACC_W-1]};
    ge     = rem_sh >= dmag_r;
    big    = |quo_r[ACC_W-1:V_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        A_IDLE: begin
          if (start) begin
            a_r     <= ACC_W'(mag_op(req.v1));
            b_r     <= mag_op(req.w1);
            neg_r   <= req.v1[OP_W-1] ^ req.w1[OP_W-1];
            v2_r    <= req.v2;
            w2_r    <= req.w2;
            acc_r   <= '0;
            dmag_r  <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
            dneg_r  <= req.den[DEN_W-1];
            phase_r <= 1'b0;
            cnt_r   <= '0;
            st_r    <= A_MUL;
          end
        end
        A_MUL: begin
          acc_r <= acc_add;
          if (cnt_r == CNT_W'(OP_W-1)) begin
            cnt_r <= '0;
            if (!phase_r) begin
              a_r     <= ACC_W'(mag_op(v2_r));
              b_r     <= mag_op(w2_r);
              neg_r   <= v2_r[OP_W-1] ^ w2_r[OP_W-1];
              phase_r <= 1'b1;
            end else begin
              st_r <= A_PREP;
            end
          end else begin
            a_r   <= a_r << 1;
            b_r   <= b_r >> 1;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        A_PREP: begin
          num_r  <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
          qneg_r <= acc_r[ACC_W-1] ^ dneg_r;
          rem_r  <= '0;
          quo_r  <= '0;
          cnt_r  <= '0;
          st_r   <= A_DIV;
        end
        A_DIV: begin
          rem_r <= ge ? rem_sh - dmag_r : rem_sh;
          quo_r <= {quo_r[ACC_W-2:0], ge};
          num_r <= num_r << 1;
          if (cnt_r == CNT_W'(ACC_W-1)) begin
            st_r   <= A_IDLE;
            done_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.busy = st_r != A_IDLE;
    rsp.done = done_r;
    rsp.rem  = rem_r[V_W-1:0];
    if (!qneg_r) begin
      rsp.quo = big ? S48MAX : $signed(quo_r[V_W-1:0]);
    end else begin
      rsp.quo = big ? S48MIN : -$signed(quo_r[V_W-1:0]);
    end
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gwan_pkg::*;

  typedef struct packed {
    logic        send_valid;
    logic [47:0] send_addr;
    logic [47:0] send_value;
    logic [47:0] send_weight;
    logic [47:0] est_value;
    logic [47:0] est_weight;
    logic [47:0] cur_local;
    logic [4:0]  nbr_count;
    logic [1:0]  status;
  } node_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] key;
    logic [47:0] addr;
    logic [47:0] mval;
    logic [47:0] mwt;
    logic [47:0] sample;
    logic [15:0] rnd;
  } node_item_t;

  localparam int NBR = 16;

  class avg_node_tracker;
    longint quantum;
    bit     slot_used[NBR];
    logic [63:0] slot_key[NBR];
    logic [47:0] slot_addr[NBR];
    longint sent_v[NBR], sent_w[NBR], recv_v[NBR], recv_w[NBR];
    longint est_v, est_w, unrecv_v, unrecv_w, last_local;
    int     used_count;
    int     errors;
    node_result_t expected_results[$];

    function new();
      quantum = QUANTUM_RST;
      for (int i = 0; i < NBR; i++) slot_used[i] = 0;
      est_v = 0;
      est_w = 64'sd1 <<< 16;
      unrecv_v = 0;
      unrecv_w = 0;
      last_local = 0;
      used_count = 0;
      errors = 0;
    endfunction

    function longint sat48(logic signed [127:0] x);
      if (x > 128'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (x < -128'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return longint'(x);
    endfunction

    function bit wmerge(longint v1, longint w1, longint v2, longint w2,
                        output longint rv, output longint rw);
      logic signed [127:0] a, b, c, d, num, den;
      if (w1 + w2 == 0) return 0;
      a = v1;
      b = w1;
      c = v2;
      d = w2;
      num = a * b + c * d;
      den = w1 + w2;
      rv = sat48(num / den);
      rw = sat48(den);
      return 1;
    endfunction

    function int find_key(logic [63:0] key);
      for (int i = 0; i < NBR; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function int add_key(logic [63:0] key, logic [47:0] addr);
      if (used_count >= NBR) return -1;
      for (int i = 0; i < NBR; i++)
        if (!slot_used[i]) begin
          slot_used[i] = 1;
          slot_key[i] = key;
          slot_addr[i] = addr;
          sent_v[i] = 0;
          sent_w[i] = 0;
          recv_v[i] = 0;
          recv_w[i] = 0;
          used_count++;
          return i;
        end
      return -1;
    endfunction

    function void note_item(node_item_t it);
      node_result_t r;
      longint mv, mw, ls, dv, dw, lim, t, h, nv, nw;
      logic signed [127:0] n, ew;
      int s, k;
      mv = longint'(signed'(it.mval));
      mw = longint'(signed'(it.mwt));
      ls = longint'(signed'(it.sample));
      r = '0;
      r.status = ST_OK;
      case (it.op)
        OP_RECV: begin
          s = find_key(it.key);
          if (s < 0) s = add_key(it.key, it.addr);
          if (s < 0) r.status = ST_FULL;
          else begin
            if (wmerge(mv, mw, recv_v[s], -recv_w[s], dv, dw)) begin
              if (wmerge(est_v, est_w, dv, dw, nv, nw)) begin
                est_v = nv;
                est_w = nw;
              end else r.status = ST_ZERO;
            end else r.status = ST_ZERO;
            recv_v[s] = mv;
            recv_w[s] = mw;
          end
        end
        OP_SEND: begin
          if (used_count == 0) r.status = ST_NONE;
          else begin
            k = int'(it.rnd) % used_count;
            for (s = 0; s < NBR; s++)
              if (slot_used[s]) begin
                if (k == 0) break;
                k--;
              end
            if (s >= NBR) s = 0;
            if (est_w >= 2 * quantum) begin
              lim = sat48(est_w - quantum);
              t = unrecv_w < lim ? unrecv_w : lim;
              if (wmerge(est_v, est_w, unrecv_v, -t, nv, nw)) begin
                est_v = nv;
                est_w = nw;
              end else r.status = ST_ZERO;
              unrecv_w = sat48(unrecv_w - t);
            end
            if (est_w >= 2 * quantum) begin
              h = est_w / 2;
              if (wmerge(sent_v[s], sent_w[s], est_v, h, nv, nw)) begin
                sent_v[s] = nv;
                sent_w[s] = nw;
              end else r.status = ST_ZERO;
              est_w = h;
            end
            r.send_valid = 1;
            r.send_addr = slot_addr[s];
            r.send_value = sent_v[s][47:0];
            r.send_weight = sent_w[s][47:0];
          end
        end
        OP_UP: begin
          if (find_key(it.key) < 0 && add_key(it.key, it.addr) < 0) r.status = ST_FULL;
        end
        OP_DOWN: begin
          s = find_key(it.key);
          if (s < 0) r.status = ST_NONE;
          else begin
            if (wmerge(est_v, est_w, sent_v[s], sent_w[s], nv, nw)) begin
              est_v = nv;
              est_w = nw;
            end else r.status = ST_ZERO;
            if (wmerge(unrecv_v, unrecv_w, recv_v[s], recv_w[s], nv, nw)) begin
              unrecv_v = nv;
              unrecv_w = nw;
            end else r.status = ST_ZERO;
            slot_used[s] = 0;
            used_count--;
          end
        end
        OP_VC: begin
          if (est_w == 0) r.status = ST_ZERO;
          else begin
            n = ls - last_local;
            n = n * 65536;
            ew = est_w;
            est_v = sat48(est_v + sat48(n / ew));
          end
          last_local = ls;
        end
        default: ;
      endcase
      r.est_value = est_v[47:0];
      r.est_weight = est_w[47:0];
      r.cur_local = last_local[47:0];
      r.nbr_count = used_count[4:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(node_result_t got);
      node_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [271:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [295:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  avg_node_tracker tracker = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left = 0;
  bit hold_req;
  bit hold_taken = 1'b0;
  logic [63:0] key_pool[20];

  gossip_weighted_average_node dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result({out_tuser[0], out_tdata[47:0], out_tdata[95:48],
                            out_tdata[143:96], out_tdata[191:144], out_tdata[239:192],
                            out_tdata[287:240], out_tdata[292:288], out_tuser[2:1]});
    if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      hold_left <= 3000;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_quantum(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= 3'd0;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    tracker.quantum = longint'(value[16:0]);
  endtask

  task automatic drain();
    while (tracker.expected_results.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic push_word(node_item_t it);
    in_tvalid <= 1;
    in_tuser <= it.op;
    in_tdata <= {it.rnd, it.sample, it.mwt, it.mval, it.addr, it.key};
    do @(posedge clk); while (!in_tready);
    tracker.note_item(it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
  endfunction

  function automatic logic [47:0] moderate(int bits);
    longint x;
    x = longint'($urandom_range(32'hFFFF_FFFF, 0)) & ((64'd1 << bits) - 1);
    if ($urandom_range(1)) x = -x;
    return x[47:0];
  endfunction

  function automatic node_item_t rand_item();
    node_item_t it;
    int p;
    p = $urandom_range(99);
    if (p < 35) it.op = OP_RECV;
    else if (p < 60) it.op = OP_SEND;
    else if (p < 72) it.op = OP_UP;
    else if (p < 84) it.op = OP_DOWN;
    else if (p < 96) it.op = OP_VC;
    else it.op = 3'($urandom_range(7, 5));
    it.key = ($urandom_range(19) == 0) ? {$urandom(), $urandom()}
                                       : key_pool[$urandom_range(19)];
    it.addr = rand48();
    it.mval = ($urandom_range(9) == 0) ? rand48() : moderate(26);
    if ($urandom_range(9) == 0) it.mwt = rand48();
    else if ($urandom_range(4) == 0) it.mwt = moderate(20);
    else it.mwt = 48'($urandom_range(1 << 20, 1 << 12));
    it.sample = ($urandom_range(9) == 0) ? rand48() : moderate(24);
    it.rnd = 16'($urandom());
    return it;
  endfunction

  initial begin
    node_item_t it;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    hold_req <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 20; i++) key_pool[i] = {$urandom(), $urandom()};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    write_quantum(32'(QUANTUM_RST));

    it = '{OP_SEND, 64'd0, 48'd0, 48'd0, 48'd0, 48'd0, 16'hFFFF};
    push_word(it);
    it = '{OP_DOWN, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 48'd0, 48'd0, 48'd0, 16'd0};
    push_word(it);
    it = '{OP_RECV, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0000_0002_0000,
           48'd0, 48'd0, 16'd0};
    push_word(it);
    it = '{OP_RECV, 64'd0, 48'd0, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'd0, 16'd0};
    push_word(it);
    it = '{OP_RECV, 64'd0, 48'd5, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'd0, 16'd0};
    push_word(it);
    it = '{OP_VC, 64'd0, 48'd0, 48'd0, 48'd0, 48'h7FFF_FFFF_FFFF, 16'd0};
    push_word(it);
    it = '{OP_VC, 64'd0, 48'd0, 48'd0, 48'd0, 48'h8000_0000_0000, 16'd0};
    push_word(it);
    it = '{OP_SEND, 64'd0, 48'd0, 48'd0, 48'd0, 48'd0, 16'd1};
    push_word(it);
    it = '{OP_UP, 64'd0, 48'd7, 48'd0, 48'd0, 48'd0, 16'd0};
    push_word(it);
    for (int i = 0; i < 15; i++) begin
      it = '{OP_UP, key_pool[i], rand48(), 48'd0, 48'd0, 48'd0, 16'd0};
      push_word(it);
    end
    it = '{OP_RECV, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 48'd1, 48'h0000_0002_0000, 48'd0, 16'd0};
    push_word(it);
    it = '{OP_DOWN, 64'd0, 48'd0, 48'd0, 48'd0, 48'd0, 16'd0};
    push_word(it);
    for (int op = 5; op < 8; op++) begin
      it = '{3'(op), 64'd0, 48'd0, 48'd0, 48'd0, 48'd0, 16'd0};
      push_word(it);
    end
    in_tvalid <= 0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_quantum(32'd0); end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  write_quantum(32'd65536); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; write_quantum(32'd2731); end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
          write_quantum($urandom_range(32'd65536, 0));
        end
      endcase
      for (int n = 0; n < 470; n++) begin
        if (ph == 0 && n == 20) hold_req <= 1;
        if (ph == 2 && n == 200) begin
          in_tvalid <= 0;
          while (tracker.expected_results.size() > 0) @(posedge clk);
        end
        push_word(rand_item());
      end
      in_tvalid <= 0;
      drain();
    end

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
